>>> rtl/gctl_pkg.sv
// ----------------------------------------------------------------------------
// gctl_pkg
// Shared types and codes for the glyph code table: status codes, item
// kinds, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package gctl_pkg;

    localparam int CW     = 9;   // glyph_count register width
    localparam int CODE_W = 16;  // character code and payload width
    localparam int SLOT_W = 8;   // slot field width on the result

    localparam logic [1:0] K_ADD  = 2'd0;
    localparam logic [1:0] K_PREP = 2'd1;
    localparam logic [1:0] K_LOOK = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_ZERO     = 3'd3,
        ST_NOTFULL  = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH,
        S_ADD_RD, S_ADD_CHK,
        S_PRE_RD, S_PRE_CHK,
        S_SRT_RD0, S_SRT_C0, S_SRT_RD, S_SRT_CMP, S_SRT_END,
        S_RUN_RD0, S_RUN_C0, S_RUN_RD, S_RUN_CMP, S_RUN_FIN,
        S_LK_RUN, S_LK_PRD, S_LK_PCHK,
        S_BS, S_BS_CHK,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_WAIT, OP_CLR, OP_TAKE, OP_RES, OP_RD_IDX, OP_RD_LAST, OP_NEXT,
        OP_ADD_WR, OP_SRT_INIT, OP_CARRY, OP_BUBBLE, OP_SRT_END,
        OP_RUN0, OP_RUN_STEP, OP_RUN_FIN, OP_LK_RUNSET, OP_LK_HIT,
        OP_BS_RD, OP_BS_STEP, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status res;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       char_zero;
        logic       at_end;
        logic       rd_zero;
        logic       rd_eq;
        logic       lim_zero;
        logic       pass_end;
        logic       swapped;
        logic       lim_one;
        logic       n_one;
        logic       run_last;
        logic       run_hit;
        logic       run_out;
        logic       bs_done;
        logic       clr_last;
    } t_stat;

endpackage

>>> rtl/gctl_ram.sv
// ----------------------------------------------------------------------------
// gctl_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gctl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/gctl_ctrl.sv
// ----------------------------------------------------------------------------
// gctl_ctrl
// Sequencer for the glyph table: clear sweep, add scan, bubble sort, run
// scan, run/binary lookup and the result handshake.
// ----------------------------------------------------------------------------
module gctl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_m_tready,
    input  logic            i_cfg_wen,
    input  gctl_pkg::t_stat i_stat,
    output gctl_pkg::t_cmd  o_cmd,
    output logic            o_s_tready,
    output logic            o_m_tvalid
);
    import gctl_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid;
    logic   take, out_free;

    assign o_s_tready = (r_state == S_IDLE) && !i_cfg_wen;
    assign take       = o_s_tready && i_s_tvalid;
    assign out_free   = !r_ovalid || i_m_tready;
    assign o_m_tvalid = r_ovalid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_cfg_wen) n_state = S_CLEAR;
                else if (take) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    K_ADD:   n_state = i_stat.char_zero ? S_DONE : S_ADD_RD;
                    K_PREP:  n_state = S_PRE_RD;
                    K_LOOK:  n_state = i_stat.char_zero ? S_DONE : S_LK_RUN;
                    default: n_state = S_DONE;
                endcase
            end
            S_ADD_RD:   n_state = i_stat.at_end ? S_DONE : S_ADD_CHK;
            S_ADD_CHK:  n_state = (i_stat.rd_zero || i_stat.rd_eq) ? S_DONE : S_ADD_RD;
            S_PRE_RD:   n_state = S_PRE_CHK;
            S_PRE_CHK: begin
                if (i_stat.rd_zero)       n_state = S_DONE;
                else if (i_stat.lim_zero) n_state = S_RUN_RD0;
                else                      n_state = S_SRT_RD0;
            end
            S_SRT_RD0:  n_state = S_SRT_C0;
            S_SRT_C0:   n_state = S_SRT_RD;
            S_SRT_RD:   n_state = S_SRT_CMP;
            S_SRT_CMP:  n_state = i_stat.pass_end ? S_SRT_END : S_SRT_RD;
            S_SRT_END:  n_state = (!i_stat.swapped || i_stat.lim_one) ? S_RUN_RD0 : S_SRT_RD0;
            S_RUN_RD0:  n_state = S_RUN_C0;
            S_RUN_C0:   n_state = i_stat.n_one ? S_RUN_FIN : S_RUN_RD;
            S_RUN_RD:   n_state = S_RUN_CMP;
            S_RUN_CMP:  n_state = i_stat.run_last ? S_RUN_FIN : S_RUN_RD;
            S_RUN_FIN:  n_state = S_DONE;
            S_LK_RUN: begin
                if (!i_stat.run_hit)     n_state = S_BS;
                else if (i_stat.run_out) n_state = S_DONE;
                else                     n_state = S_LK_PRD;
            end
            S_LK_PRD:   n_state = S_LK_PCHK;
            S_LK_PCHK:  n_state = S_DONE;
            S_BS:       n_state = i_stat.bs_done ? S_DONE : S_BS_CHK;
            S_BS_CHK:   n_state = i_stat.rd_eq ? S_DONE : S_BS;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op  = OP_WAIT;
        o_cmd.res = ST_NOTFOUND;
        unique case (r_state)
            S_CLEAR:    o_cmd.op = OP_CLR;
            S_IDLE:     if (take) o_cmd.op = OP_TAKE;
            S_DISPATCH: begin
                case (i_stat.kind)
                    K_ADD: begin
                        if (i_stat.char_zero) begin
                            o_cmd.op  = OP_RES;
                            o_cmd.res = ST_ZERO;
                        end
                    end
                    K_PREP:  o_cmd.op = OP_WAIT;
                    K_LOOK:  if (i_stat.char_zero) o_cmd.op = OP_RES;
                    default: o_cmd.op = OP_RES;
                endcase
            end
            S_ADD_RD: begin
                if (i_stat.at_end) begin
                    o_cmd.op  = OP_RES;
                    o_cmd.res = ST_FULL;
                end else begin
                    o_cmd.op = OP_RD_IDX;
                end
            end
            S_ADD_CHK: begin
                if (i_stat.rd_zero) begin
                    o_cmd.op = OP_ADD_WR;
                end else if (i_stat.rd_eq) begin
                    o_cmd.op  = OP_RES;
                    o_cmd.res = ST_DUP;
                end else begin
                    o_cmd.op = OP_NEXT;
                end
            end
            S_PRE_RD:   o_cmd.op = OP_RD_LAST;
            S_PRE_CHK: begin
                if (i_stat.rd_zero) begin
                    o_cmd.op  = OP_RES;
                    o_cmd.res = ST_NOTFULL;
                end else begin
                    o_cmd.op = OP_SRT_INIT;
                end
            end
            S_SRT_RD0, S_SRT_RD, S_RUN_RD0, S_RUN_RD, S_LK_PRD: o_cmd.op = OP_RD_IDX;
            S_SRT_C0:   o_cmd.op = OP_CARRY;
            S_SRT_CMP:  o_cmd.op = OP_BUBBLE;
            S_SRT_END:  o_cmd.op = OP_SRT_END;
            S_RUN_C0:   o_cmd.op = OP_RUN0;
            S_RUN_CMP:  o_cmd.op = OP_RUN_STEP;
            S_RUN_FIN:  o_cmd.op = OP_RUN_FIN;
            S_LK_RUN: begin
                if (i_stat.run_hit) o_cmd.op = i_stat.run_out ? OP_RES : OP_LK_RUNSET;
            end
            S_LK_PCHK:  o_cmd.op = OP_LK_HIT;
            S_BS:       o_cmd.op = i_stat.bs_done ? OP_RES : OP_BS_RD;
            S_BS_CHK:   o_cmd.op = i_stat.rd_eq ? OP_LK_HIT : OP_BS_STEP;
            S_DONE:     if (out_free) o_cmd.op = OP_EMIT;
            default:    o_cmd.op = OP_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == OP_EMIT) r_ovalid <= 1'b1;
            else if (i_m_tready)     r_ovalid <= 1'b0;
        end
    end

    // one item in flight: no new word straight after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("gctl_ctrl: input taken while an item is in flight");

    // hold the finished result while the output word is still waiting
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_ovalid && !i_m_tready) |=> (r_state == S_DONE))
        else $error("gctl_ctrl: result left while output blocked");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ovalid ##1 r_ovalid) |-> ($past(r_state) == S_DONE))
        else $error("gctl_ctrl: output raised outside the done state");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cfg_wen) |=> (r_state == S_CLEAR))
        else $error("gctl_ctrl: register write did not start the clear sweep");

endmodule

>>> rtl/gctl_dp.sv
// ----------------------------------------------------------------------------
// gctl_dp
// Datapath for the glyph table: table RAM, scan index, sort carry, run
// cache, binary search bounds and the result registers.
// ----------------------------------------------------------------------------
module gctl_dp #(
    parameter int DEPTH     = 256,
    parameter int RUN_SLOTS = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gctl_pkg::t_cmd            i_cmd,
    input  logic                      i_cfg_wen,
    input  logic [gctl_pkg::CW-1:0]   i_cfg_wdata,
    input  logic [31:0]               i_s_tdata,
    input  logic [1:0]                i_s_tuser,
    output gctl_pkg::t_stat           o_stat,
    output logic [23:0]               o_m_tdata,
    output logic [2:0]                o_m_tuser
);
    import gctl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int IW = AW + 1;
    localparam int XW = ((AW > CW) ? AW : CW) + 2;
    localparam int RX = ((AW > CODE_W) ? AW : CODE_W) + 2;
    localparam int DW = 2 * CODE_W;
    localparam logic [CW-1:0] CNT_RST = CW'((DEPTH < 256) ? DEPTH : 256);

    logic [1:0]            r_kind;
    logic [CODE_W-1:0]     r_char, r_pay;
    logic [CW-1:0]         r_cnt, cfg_cnt;
    logic [IW-1:0]         r_idx;
    logic [AW-1:0]         r_limit, r_start;
    logic                  r_swapped;
    logic signed [XW-1:0]  r_lo, r_hi, mid;
    logic [DW-1:0]         r_carry;
    logic [CODE_W-1:0]     r_scode, r_prev;
    logic [CODE_W-1:0]     r_rfirst [RUN_SLOTS];
    logic [CODE_W-1:0]     r_rlast  [RUN_SLOTS];
    logic [AW-1:0]         r_rbase  [RUN_SLOTS];
    logic [CODE_W-1:0]     n_rfirst [RUN_SLOTS];
    logic [CODE_W-1:0]     n_rlast  [RUN_SLOTS];
    logic [AW-1:0]         n_rbase  [RUN_SLOTS];
    t_status               r_pst, r_ost;
    logic [SLOT_W-1:0]     r_pslot, r_oslot;
    logic [CODE_W-1:0]     r_pfp, r_ofp;

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DW-1:0]         wdata, rdata;
    logic [CODE_W-1:0]     rd_code, rd_pay;
    logic                  gt, brk, rec_en, run_hit;
    logic [RX-1:0]         run_idx;

    assign rd_code = rdata[CODE_W-1:0];
    assign rd_pay  = rdata[DW-1:CODE_W];
    assign gt      = r_carry[CODE_W-1:0] > rd_code;
    assign brk     = (CODE_W + 1)'(rd_code) != ((CODE_W + 1)'(r_prev) + 1'b1);
    assign rec_en  = ((i_cmd.op == OP_RUN_STEP) && brk) || (i_cmd.op == OP_RUN_FIN);
    assign mid     = (r_lo + r_hi) >>> 1;

    always_comb begin
        if (i_cfg_wdata == '0)             cfg_cnt = CW'(1);
        else if (int'(i_cfg_wdata) > DEPTH) cfg_cnt = CW'(DEPTH);
        else                               cfg_cnt = i_cfg_wdata;
    end

    // table port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = '0;
        raddr = r_idx[AW-1:0];
        case (i_cmd.op)
            OP_CLR:     we = 1'b1;
            OP_ADD_WR: begin
                we    = 1'b1;
                wdata = {r_pay, r_char};
            end
            OP_BUBBLE: begin
                we    = 1'b1;
                waddr = AW'(r_idx - 1'b1);
                wdata = gt ? rdata : r_carry;
            end
            OP_SRT_END: begin
                we    = 1'b1;
                waddr = AW'(r_idx - 1'b1);
                wdata = r_carry;
            end
            OP_RD_LAST: raddr = AW'(r_cnt - 1'b1);
            OP_BS_RD:   raddr = mid[AW-1:0];
            default:    ;
        endcase
    end

    gctl_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // first cached run that covers the code wins
    always_comb begin
        run_hit = 1'b0;
        run_idx = '0;
        for (int k = 0; k < RUN_SLOTS; k++) begin
            if (!run_hit && r_rfirst[k] != '0 && r_char >= r_rfirst[k] &&
                r_char <= r_rlast[k]) begin
                run_hit = 1'b1;
                run_idx = RX'(r_rbase[k]) + RX'(CODE_W'(r_char - r_rfirst[k]));
            end
        end
    end

    // insert a run ahead of every strictly shorter one, push the rest down
    always_comb begin
        logic              ins;
        logic [CODE_W-1:0] rec_len, c_first, c_last;
        logic [AW-1:0]     c_base;
        ins     = 1'b0;
        rec_len = r_prev - r_scode;
        c_first = '0;
        c_last  = '0;
        c_base  = '0;
        for (int k = 0; k < RUN_SLOTS; k++) begin
            n_rfirst[k] = r_rfirst[k];
            n_rlast[k]  = r_rlast[k];
            n_rbase[k]  = r_rbase[k];
            if (rec_en) begin
                if (ins) begin
                    n_rfirst[k] = c_first;
                    n_rlast[k]  = c_last;
                    n_rbase[k]  = c_base;
                    c_first     = r_rfirst[k];
                    c_last      = r_rlast[k];
                    c_base      = r_rbase[k];
                end else if (rec_len > (r_rlast[k] - r_rfirst[k])) begin
                    ins         = 1'b1;
                    n_rfirst[k] = r_scode;
                    n_rlast[k]  = r_prev;
                    n_rbase[k]  = r_start;
                    c_first     = r_rfirst[k];
                    c_last      = r_rlast[k];
                    c_base      = r_rbase[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= CNT_RST;
            r_idx     <= '0;
            r_swapped <= 1'b0;
            for (int k = 0; k < RUN_SLOTS; k++) begin
                r_rfirst[k] <= '0;
                r_rlast[k]  <= '0;
                r_rbase[k]  <= '0;
            end
        end else if (i_cfg_wen) begin
            r_cnt <= cfg_cnt;
            r_idx <= '0;
            for (int k = 0; k < RUN_SLOTS; k++) begin
                r_rfirst[k] <= '0;
                r_rlast[k]  <= '0;
                r_rbase[k]  <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_CLR, OP_NEXT, OP_CARRY: r_idx <= r_idx + 1'b1;
                OP_TAKE:     r_idx <= '0;
                OP_SRT_INIT: begin
                    r_idx     <= '0;
                    r_swapped <= 1'b0;
                    for (int k = 0; k < RUN_SLOTS; k++) begin
                        r_rfirst[k] <= '0;
                        r_rlast[k]  <= '0;
                        r_rbase[k]  <= '0;
                    end
                end
                OP_BUBBLE: begin
                    r_idx <= r_idx + 1'b1;
                    if (gt) r_swapped <= 1'b1;
                end
                OP_SRT_END: begin
                    r_idx     <= '0;
                    r_swapped <= 1'b0;
                end
                OP_RUN0:     r_idx <= IW'(1);
                OP_RUN_STEP, OP_RUN_FIN: begin
                    if (i_cmd.op == OP_RUN_STEP) r_idx <= r_idx + 1'b1;
                    r_rfirst <= n_rfirst;
                    r_rlast  <= n_rlast;
                    r_rbase  <= n_rbase;
                end
                OP_LK_RUNSET: r_idx <= IW'(run_idx);
                OP_BS_RD:     r_idx <= IW'(mid);
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_TAKE: begin
                r_kind  <= i_s_tuser;
                r_char  <= i_s_tdata[CODE_W-1:0];
                r_pay   <= i_s_tdata[DW-1:CODE_W];
                r_lo    <= '0;
                r_hi    <= $signed(XW'(r_cnt)) - XW'(1);
                r_limit <= AW'(r_cnt - 1'b1);
            end
            OP_RES: begin
                r_pst   <= i_cmd.res;
                r_pslot <= '0;
                r_pfp   <= '0;
            end
            OP_ADD_WR: begin
                r_pst   <= ST_OK;
                r_pslot <= SLOT_W'(r_idx);
                r_pfp   <= '0;
            end
            OP_CARRY:   r_carry <= rdata;
            OP_BUBBLE:  if (!gt) r_carry <= rdata;
            OP_SRT_END: r_limit <= r_limit - 1'b1;
            OP_RUN0: begin
                r_start <= '0;
                r_scode <= rd_code;
                r_prev  <= rd_code;
            end
            OP_RUN_STEP: begin
                if (brk) begin
                    r_start <= r_idx[AW-1:0];
                    r_scode <= rd_code;
                end
                r_prev <= rd_code;
            end
            OP_RUN_FIN: begin
                r_pst   <= ST_OK;
                r_pslot <= '0;
                r_pfp   <= '0;
            end
            OP_LK_HIT: begin
                r_pst   <= ST_OK;
                r_pslot <= SLOT_W'(r_idx);
                r_pfp   <= rd_pay;
            end
            OP_BS_STEP: begin
                if (rd_code < r_char) r_lo <= $signed(XW'(r_idx)) + XW'(1);
                else                  r_hi <= $signed(XW'(r_idx)) - XW'(1);
            end
            OP_EMIT: begin
                r_ost   <= r_pst;
                r_oslot <= r_pslot;
                r_ofp   <= r_pfp;
            end
            default: ;
        endcase
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.char_zero = (r_char == '0);
    assign o_stat.at_end    = XW'(r_idx) >= XW'(r_cnt);
    assign o_stat.rd_zero   = (rd_code == '0);
    assign o_stat.rd_eq     = (rd_code == r_char);
    assign o_stat.lim_zero  = (r_limit == '0);
    assign o_stat.pass_end  = (r_idx == IW'(r_limit));
    assign o_stat.swapped   = r_swapped;
    assign o_stat.lim_one   = (r_limit == AW'(1));
    assign o_stat.n_one     = (r_cnt == CW'(1));
    assign o_stat.run_last  = XW'(r_idx) == (XW'(r_cnt) - XW'(1));
    assign o_stat.run_hit   = run_hit;
    assign o_stat.run_out   = run_idx >= RX'(r_cnt);
    assign o_stat.bs_done   = r_lo > r_hi;
    assign o_stat.clr_last  = (r_idx == IW'(DEPTH - 1));

    assign o_m_tdata = {r_ofp, r_oslot};
    assign o_m_tuser = r_ost;

endmodule

>>> rtl/glyph_code_table_lookup.sv
// ----------------------------------------------------------------------------
// glyph_code_table_lookup
// Table of character codes with payloads: add, sort with run cache, lookup.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 content
//  s_axis    in   s_axis_tvalid/tready      tdata: character, payload
//                                           tuser: kind
//  m_axis    out  m_axis_tvalid/tready      tdata: slot, found_payload
//                                           tuser: status
//  cfg       in   i_cfg_wen                 i_cfg_wdata: glyph_count
//
//  One item at a time through a single table RAM (one write, one read port).
//  Lookup: a run-cache hit reads the slot directly, else a binary search.
//  Add: a linear scan of the slots. Prepare: a bubble sort of the table,
//  then a run scan over every slot.
//  After reset and after a glyph_count write made while idle, a clear sweep
//  over all DEPTH slots runs with s_axis_tready low. A stalled m_axis holds the next result.
// ----------------------------------------------------------------------------
module glyph_code_table_lookup #(
    parameter int DEPTH     = 256,
    parameter int RUN_SLOTS = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // character[15:0], payload[31:16]
    input  logic [1:0]              s_axis_tuser,   // kind[1:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // slot[7:0], found_payload[23:8]
    output logic [2:0]              m_axis_tuser,   // status[2:0]
    input  logic                    i_cfg_wen,
    input  logic [gctl_pkg::CW-1:0] i_cfg_wdata
);
    import gctl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gctl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_cfg_wen  (i_cfg_wen),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid)
    );

    gctl_dp #(.DEPTH(DEPTH), .RUN_SLOTS(RUN_SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_stat      (stat),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph code table lookup testbench
// Drives add, prepare and lookup words through the stream ports under random
// back-pressure, predicts each result with a behavioural copy of the table,
// its sort and its run cache or takes it from a directed row, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
    import gctl_pkg::*;

    localparam int TBL_DEPTH = 256;
    localparam int RUNS      = 3;
    localparam int KIND_BAD  = 3;

    typedef struct {
        t_status    status;
        logic [7:0] slot;
        logic [15:0] payload;
    } t_answer;

    typedef struct {
        bit          is_cfg;
        logic [8:0]  cfg_val;
        logic [1:0]  kind;
        logic [15:0] code;
        logic [15:0] pay;
        bit          typed;
        t_status     status;
        logic [7:0]  slot;
        logic [15:0] fpay;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // character[15:0], payload[31:16]
    logic [1:0]  s_axis_tuser;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // slot[7:0], found_payload[23:8]
    logic [2:0]  m_axis_tuser;   // status[2:0]
    logic        i_cfg_wen;
    logic [8:0]  i_cfg_wdata;

    glyph_code_table_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // shadow copy of the table
    logic [15:0] code_mem [TBL_DEPTH];
    logic [15:0] pay_mem  [TBL_DEPTH];
    logic [15:0] run_lo   [RUNS];
    logic [15:0] run_hi   [RUNS];
    int          run_at   [RUNS];
    int          glyph_cnt;

    t_answer pending_answers [$];
    int      mismatches;
    int      words_sent;
    int      idle_mode;
    int      recv_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    function automatic void empty_table();
        for (int i = 0; i < TBL_DEPTH; i++) begin
            code_mem[i] = '0;
            pay_mem[i]  = '0;
        end
        for (int r = 0; r < RUNS; r++) begin
            run_lo[r] = '0;
            run_hi[r] = '0;
            run_at[r] = 0;
        end
    endfunction

    function automatic void keep_run(logic [15:0] first, logic [15:0] last, int base);
        logic [15:0] len;
        logic [15:0] held;
        int pos;
        len = last - first;
        pos = 0;
        while (pos < RUNS) begin
            held = run_hi[pos] - run_lo[pos];
            if (len > held)
                break;
            pos++;
        end
        if (pos >= RUNS)
            return;
        for (int k = RUNS - 1; k > pos; k--) begin
            run_lo[k] = run_lo[k-1];
            run_hi[k] = run_hi[k-1];
            run_at[k] = run_at[k-1];
        end
        run_lo[pos] = first;
        run_hi[pos] = last;
        run_at[pos] = base;
    endfunction

    function automatic t_answer table_answer(logic [1:0] kind, logic [15:0] code,
                                             logic [15:0] pay);
        t_answer a;
        int p, lim, last_swap, start, lo, hi, mid;
        bit swapped, hit;
        logic [15:0] tc, tp;
        a.status = ST_NOTFOUND;
        a.slot = '0;
        a.payload = '0;
        case (kind)
            K_ADD: begin
                if (code == 0) begin
                    a.status = ST_ZERO;
                end else begin
                    p = 0;
                    while (p < glyph_cnt && code_mem[p] != 0 && code_mem[p] != code)
                        p++;
                    if (p >= glyph_cnt) begin
                        a.status = ST_FULL;
                    end else if (code_mem[p] == code) begin
                        a.status = ST_DUP;
                    end else begin
                        code_mem[p] = code;
                        pay_mem[p]  = pay;
                        a.status = ST_OK;
                        a.slot = p[7:0];
                    end
                end
            end
            K_PREP: begin
                if (code_mem[glyph_cnt-1] == 0) begin
                    a.status = ST_NOTFULL;
                end else begin
                    lim = glyph_cnt - 1;
                    swapped = 1'b1;
                    while (swapped && lim > 0) begin
                        last_swap = 0;
                        swapped = 1'b0;
                        for (int i = 0; i < lim; i++) begin
                            if (code_mem[i] > code_mem[i+1]) begin
                                tc = code_mem[i];
                                tp = pay_mem[i];
                                code_mem[i]   = code_mem[i+1];
                                pay_mem[i]    = pay_mem[i+1];
                                code_mem[i+1] = tc;
                                pay_mem[i+1]  = tp;
                                swapped = 1'b1;
                                last_swap = i;
                            end
                        end
                        lim = last_swap;
                    end
                    for (int r = 0; r < RUNS; r++) begin
                        run_lo[r] = '0;
                        run_hi[r] = '0;
                        run_at[r] = 0;
                    end
                    start = 0;
                    for (int i = 1; i < glyph_cnt; i++) begin
                        if (int'(code_mem[i]) != int'(code_mem[i-1]) + 1) begin
                            keep_run(code_mem[start], code_mem[i-1], start);
                            start = i;
                        end
                    end
                    keep_run(code_mem[start], code_mem[glyph_cnt-1], start);
                    a.status = ST_OK;
                end
            end
            K_LOOK: begin
                if (code != 0) begin
                    hit = 1'b0;
                    for (int r = 0; r < RUNS && !hit; r++) begin
                        if (run_lo[r] != 0 && code >= run_lo[r] && code <= run_hi[r]) begin
                            hit = 1'b1;
                            p = run_at[r] + int'(code - run_lo[r]);
                            if (p < glyph_cnt) begin
                                a.status = ST_OK;
                                a.slot = p[7:0];
                                a.payload = pay_mem[p];
                            end
                        end
                    end
                    if (!hit) begin
                        lo = 0;
                        hi = glyph_cnt - 1;
                        while (lo <= hi) begin
                            mid = lo + (hi - lo) / 2;
                            if (code_mem[mid] == code) begin
                                a.status = ST_OK;
                                a.slot = mid[7:0];
                                a.payload = pay_mem[mid];
                                break;
                            end
                            if (code_mem[mid] < code)
                                lo = mid + 1;
                            else
                                hi = mid - 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic int send_idle_pct();
        return (idle_mode == 0) ? 36 : (idle_mode == 1) ? 62 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (idle_mode == 0) ? 62 : (idle_mode == 1) ? 36 : 0;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // offer one word, hold it until accepted, then predict its result
    task automatic put_word(logic [1:0] kind, logic [15:0] code, logic [15:0] pay);
        while ($urandom_range(99) < send_idle_pct()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pay, code};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_answers.push_back(table_answer(kind, code, pay));
        words_sent++;
        if (words_sent == 120)
            recv_hold = 400;
        idle_mode = (words_sent < 350) ? 0 : (words_sent < 700) ? 1 : 2;
    endtask

    task automatic set_glyph_count(logic [8:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        glyph_cnt = (value == 0) ? 1 : (value > TBL_DEPTH) ? TBL_DEPTH : int'(value);
        empty_table();
    endtask

    // result side: check accepted words, vary tready
    initial begin
        t_answer want;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_answers.size() == 0) begin
                    report("unexpected word", {m_axis_tuser, m_axis_tdata}, 0);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_axis_tuser != want.status)
                        report("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[7:0] != want.slot)
                        report("slot", m_axis_tdata[7:0], want.slot);
                    if (m_axis_tdata[23:8] != want.payload)
                        report("found_payload", m_axis_tdata[23:8], want.payload);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct());
            end
        end
    end

    initial begin
        t_row rows [$];
        logic [15:0] codes [$];
        bit used [int];
        logic [15:0] c, tc;
        logic [8:0] cfg;
        int n, j, base, len, phase, big_done;

        mismatches = 0;
        words_sent = 0;
        idle_mode  = 0;
        recv_hold  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= '0;
        glyph_cnt = TBL_DEPTH;
        empty_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back('{0, 0, K_LOOK, 16'h0000, 16'h0000, 1, ST_NOTFOUND, 0, 0});
        rows.push_back('{0, 0, K_PREP, 16'h0000, 16'h0000, 1, ST_NOTFULL, 0, 0});
        rows.push_back('{0, 0, K_ADD,  16'h0000, 16'h1111, 1, ST_ZERO, 0, 0});
        rows.push_back('{0, 0, 2'(KIND_BAD), 16'hFFFF, 16'hFFFF, 1, ST_NOTFOUND, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'h1234, 16'h0000, 1, ST_NOTFOUND, 0, 0});
        rows.push_back('{1, 9'd4, K_ADD, 0, 0, 0, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_ADD,  16'hFFFF, 16'h0000, 1, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_ADD,  16'hFFFE, 16'hFFFF, 1, ST_OK, 1, 0});
        rows.push_back('{0, 0, K_ADD,  16'hFFFF, 16'h5555, 1, ST_DUP, 0, 0});
        rows.push_back('{0, 0, K_PREP, 16'h0000, 16'h0000, 1, ST_NOTFULL, 0, 0});
        rows.push_back('{0, 0, K_ADD,  16'h0003, 16'h1234, 1, ST_OK, 2, 0});
        rows.push_back('{0, 0, K_ADD,  16'h0002, 16'h0005, 1, ST_OK, 3, 0});
        rows.push_back('{0, 0, K_ADD,  16'h0009, 16'h0001, 1, ST_FULL, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'h0002, 16'h0000, 0, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_PREP, 16'h0000, 16'h0000, 1, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'hFFFF, 16'h0000, 0, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'h0002, 16'h0000, 0, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'h0004, 16'h0000, 0, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'h0000, 16'h0000, 1, ST_NOTFOUND, 0, 0});
        rows.push_back('{1, 9'd0, K_ADD, 0, 0, 0, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_ADD,  16'h0001, 16'hABCD, 1, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_ADD,  16'h0002, 16'h0000, 1, ST_FULL, 0, 0});
        rows.push_back('{0, 0, K_PREP, 16'h0000, 16'h0000, 1, ST_OK, 0, 0});
        rows.push_back('{0, 0, K_LOOK, 16'h0001, 16'h0000, 0, ST_OK, 0, 0});
        rows.push_back('{1, 9'd511, K_ADD, 0, 0, 0, ST_OK, 0, 0});

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                set_glyph_count(rows[i].cfg_val);
            end else begin
                put_word(rows[i].kind, rows[i].code, rows[i].pay);
                if (rows[i].typed)
                    pending_answers[$] = '{rows[i].status, rows[i].slot, rows[i].fpay};
            end
        end

        phase = 0;
        big_done = 0;
        while (words_sent < 1050) begin
            if ((phase == 3 && big_done == 0) || (phase == 9 && big_done == 1)) begin
                cfg = big_done ? 9'($urandom_range(257, 511)) : 9'd256;
                big_done++;
            end else if ($urandom_range(9) == 0) begin
                cfg = 9'($urandom_range(1));
            end else begin
                cfg = 9'($urandom_range(2, 40));
            end
            set_glyph_count(cfg);
            n = glyph_cnt;
            phase++;

            if ($urandom_range(7) == 0) begin
                // noise: arbitrary kinds and codes
                repeat ($urandom_range(1, 2 * n + 2))
                    put_word(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
                continue;
            end

            // distinct codes in a few consecutive runs, then shuffled
            codes.delete();
            used.delete();
            while (codes.size() < n) begin
                base = $urandom_range(1, 16'hFFFF);
                len = $urandom_range(1, 8);
                for (int k = 0; k < len && codes.size() < n; k++) begin
                    c = 16'(base + k);
                    if (c != 0 && !used.exists(c)) begin
                        used[c] = 1;
                        codes.push_back(c);
                    end
                end
            end
            for (int k = n - 1; k > 0; k--) begin
                j = $urandom_range(k);
                tc = codes[k];
                codes[k] = codes[j];
                codes[j] = tc;
            end

            foreach (codes[k]) begin
                put_word(K_ADD, codes[k], 16'($urandom));
                case ($urandom_range(15))
                    0: put_word(K_LOOK, codes[$urandom_range(k)], 16'($urandom));
                    1: put_word(K_ADD, codes[$urandom_range(k)], 16'($urandom));
                    2: put_word(K_ADD, 16'h0000, 16'($urandom));
                    3: put_word(K_PREP, 16'($urandom), 16'($urandom));
                    default: ;
                endcase
            end
            put_word(K_ADD, 16'($urandom_range(1, 16'hFFFF)), 16'($urandom));
            put_word(K_PREP, 16'($urandom), 16'($urandom));
            if ($urandom_range(5) == 0)
                put_word(K_PREP, 16'($urandom), 16'($urandom));

            repeat (((n < 12) ? n : 12) + 4) begin
                c = codes[$urandom_range(n - 1)];
                case ($urandom_range(7))
                    0: c = c + 16'd1;
                    1: c = c - 16'd1;
                    2: c = 16'($urandom);
                    3: c = 16'h0000;
                    default: ;
                endcase
                put_word(K_LOOK, c, 16'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/gctl_pkg.sv
rtl/gctl_ram.sv
rtl/gctl_ctrl.sv
rtl/gctl_dp.sv
rtl/glyph_code_table_lookup.sv
bench/tb.sv
